// ----- design/cgsfb_pkg.sv -----
`default_nettype none

package cgsfb_pkg;

    // Ring and shifter sizes
    localparam int TX_DEPTH      = 64;
    localparam int RX_DEPTH      = 64;
    localparam int HW_FIFO_DEPTH = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int INFL_CAP      = 16;

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int MOVED_W = $clog2(MAX_RESULTS + 1);

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 16;
    localparam int HW_W     = 5;
    localparam int KIND_W   = 2;
    localparam int INFL_W   = 5;
    localparam int DROP_W   = 16;
    localparam int LVL_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int SUM_W    = 8;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STAT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFL_LIMIT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] CHAR_BITS_RST  = 5'd8;
    localparam logic [CFG_DATA_W-1:0] INFL_LIMIT_RST = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STAT,
        S_POP,
        S_PCHK,
        S_PLOAD,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic step;
        logic ld_stat;
        logic ld_pop;
        logic ld_pump;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              eob;
        logic              pump_ok;
        logic              out_last;
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] data;
        logic              eob;
        logic [HW_W-1:0]   hw_level;
    } t_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
        logic              last;
        logic              accepted;
        logic              busy_res;
        logic [INFL_W-1:0] in_flight;
        logic [DROP_W-1:0] overflow_count;
        logic [LVL_W-1:0]  rx_level;
        logic [LVL_W-1:0]  tx_level;
    } t_result;

endpackage

`default_nettype wire

// ----- design/cgsfb_ifs.sv -----
`default_nettype none

interface cgsfb_in_if import cgsfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] data;
    logic              end_of_burst;
    logic [HW_W-1:0]   hw_tx_level;

    modport source (output valid, func, data, end_of_burst, hw_tx_level, input ready);
    modport sink (input valid, func, data, end_of_burst, hw_tx_level, output ready);
endinterface

interface cgsfb_out_if import cgsfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              accepted;
    logic              busy_res;
    logic [INFL_W-1:0] in_flight;
    logic [DROP_W-1:0] overflow_count;
    logic [LVL_W-1:0]  rx_level;
    logic [LVL_W-1:0]  tx_level;

    modport source (output valid, kind, word, last, accepted, busy_res, in_flight,
                    overflow_count, rx_level, tx_level, input ready);
    modport sink (input valid, kind, word, last, accepted, busy_res, in_flight,
                  overflow_count, rx_level, tx_level, output ready);
endinterface

interface cgsfb_cfg_if import cgsfb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/credit_gated_spi_fifo_bridge.sv -----
`default_nettype none

// Credit-gated bridge between a host and a full-duplex SPI shifter. Each request on i_in
// pushes a host word into the transmit ring (dropped when full), delivers a word returned
// by the shifter into the receive ring (dropped and counted when full, in-flight count
// decremented and held at zero), pops one received word, or flushes the receive ring.
// A push or returned-word request flagged end_of_burst runs the pump: it moves words from
// the transmit ring to the shifter, masked to char_bits and left-justified, while the
// in-flight count is below inflight_limit, the hardware FIFO level reported with the
// request plus the words moved so far is below its depth, and the ring is not empty.
// Every moved word is one result of kind "sent"; a request that moves none gives one
// status result, a pop gives one result carrying the popped word. The last result of a
// request has last set. One request is handled at a time: a pop, a flush, or a push or
// returned-word request without end_of_burst goes from execute to loading the result
// register, then waits for the output to be taken before it returns to idle. With
// end_of_burst a pump check follows execute; a request that moves nothing then loads
// a status result, and a pump moves one word at a time: check with the read of the
// transmit ring RAM, load of the output register, and wait for the output to be taken.
// Configuration writes on i_cfg are always taken; issue them only while the block is idle.
// Both rings are RAMs with no clearing pass, so the block takes requests right after reset.

module credit_gated_spi_fifo_bridge import cgsfb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    cgsfb_in_if.sink      i_in,
    cgsfb_out_if.source   o_out,
    cgsfb_cfg_if.sink     i_cfg
);

    t_cmd    cmd;
    t_status stat;
    t_item   item;
    t_cfg_wr cfg_wr;
    t_result res;
    logic    in_ready;
    logic    out_valid;

    // Collect the request payload into one bundle for the datapath.
    assign item.func     = i_in.func;
    assign item.data     = i_in.data;
    assign item.eob      = i_in.end_of_burst;
    assign item.hw_level = i_in.hw_tx_level;

    // Configuration is never back-pressured.
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.we    = i_cfg.valid;
    assign cfg_wr.idx   = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    cgsfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    cgsfb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cfg   (cfg_wr),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (res)
    );

    // Hold the result register on the output until the sink takes it.
    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.kind           = res.kind;
    assign o_out.word           = res.word;
    assign o_out.last           = res.last;
    assign o_out.accepted       = res.accepted;
    assign o_out.busy_res       = res.busy_res;
    assign o_out.in_flight      = res.in_flight;
    assign o_out.overflow_count = res.overflow_count;
    assign o_out.rx_level       = res.rx_level;
    assign o_out.tx_level       = res.tx_level;

endmodule

`default_nettype wire

// ----- design/cgsfb_ram.sv -----
`default_nettype none

module cgsfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/cgsfb_ctrl.sv -----
`default_nettype none

module cgsfb_ctrl import cgsfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_stat,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_stat.func)
                    FUNC_POP:   n_state = S_POP;
                    FUNC_FLUSH: n_state = S_STAT;
                    default:    n_state = i_stat.eob ? S_PCHK : S_STAT;
                endcase
            end
            S_PCHK: begin
                n_state = i_stat.pump_ok ? S_PLOAD : S_STAT;
            end
            S_STAT, S_POP, S_PLOAD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) n_state = i_stat.out_last ? S_IDLE : S_PCHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_EXEC:  o_cmd.exec    = 1'b1;
            S_PCHK:  o_cmd.step    = i_stat.pump_ok;
            S_STAT:  o_cmd.ld_stat = 1'b1;
            S_POP:   o_cmd.ld_pop  = 1'b1;
            S_PLOAD: o_cmd.ld_pump = 1'b1;
            S_WAIT:  o_out_valid   = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/cgsfb_dp.sv -----
`default_nettype none

module cgsfb_dp import cgsfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_item   i_item,
    input  wire t_cfg_wr i_cfg,
    input  wire t_cmd    i_cmd,
    output t_status      o_stat,
    output t_result      o_res
);

    // Configuration
    logic [CFG_DATA_W-1:0] r_char_bits, n_char_bits;
    logic [CFG_DATA_W-1:0] r_infl_lim, n_infl_lim;

    // Latched request
    t_item               r_item, n_item;
    logic                r_acc, n_acc;
    logic [MOVED_W-1:0]  r_moved, n_moved;

    // Ring pointers and counters
    logic [TX_AW-1:0]    r_tx_head, n_tx_head;
    logic [TX_CW-1:0]    r_tx_cnt, n_tx_cnt;
    logic [RX_AW-1:0]    r_rx_head, n_rx_head;
    logic [RX_CW-1:0]    r_rx_cnt, n_rx_cnt;
    logic [INFL_W-1:0]   r_inflight, n_inflight;
    logic [DROP_W-1:0]   r_dropped, n_dropped;

    t_result             r_res, n_res;

    logic [CFG_DATA_W-1:0] eff_bits;
    logic [CFG_DATA_W-1:0] lsh;
    logic [WORD_W-1:0]     mask;
    logic [CFG_DATA_W-1:0] lim;
    logic [WORD_W-1:0]     masked_in;
    logic [TX_AW:0]        tx_tsum;
    logic [TX_AW-1:0]      tx_tail;
    logic [RX_AW:0]        rx_tsum;
    logic [RX_AW-1:0]      rx_tail;
    logic                  pump_ok;
    logic                  busy;

    logic                  tx_we, tx_re, rx_we, rx_re;
    logic [WORD_W-1:0]     tx_rdata, rx_rdata;

    always_comb begin
        if (r_char_bits == '0) begin
            eff_bits = CFG_DATA_W'(1);
        end else if (r_char_bits > CFG_DATA_W'(WORD_W)) begin
            eff_bits = CFG_DATA_W'(WORD_W);
        end else begin
            eff_bits = r_char_bits;
        end
        lsh       = CFG_DATA_W'(WORD_W) - eff_bits;
        mask      = {WORD_W{1'b1}} >> lsh;
        lim       = (r_infl_lim > CFG_DATA_W'(INFL_CAP)) ? CFG_DATA_W'(INFL_CAP) : r_infl_lim;
        masked_in = r_item.data & mask;

        tx_tsum = (TX_AW + 1)'(r_tx_head) + (TX_AW + 1)'(r_tx_cnt);
        if (tx_tsum >= (TX_AW + 1)'(TX_DEPTH)) tx_tsum = tx_tsum - (TX_AW + 1)'(TX_DEPTH);
        tx_tail = tx_tsum[TX_AW-1:0];
        rx_tsum = (RX_AW + 1)'(r_rx_head) + (RX_AW + 1)'(r_rx_cnt);
        if (rx_tsum >= (RX_AW + 1)'(RX_DEPTH)) rx_tsum = rx_tsum - (RX_AW + 1)'(RX_DEPTH);
        rx_tail = rx_tsum[RX_AW-1:0];

        pump_ok = (SUM_W'(r_moved) < SUM_W'(MAX_RESULTS))
               && (SUM_W'(r_inflight) < SUM_W'(lim))
               && ((SUM_W'(r_item.hw_level) + SUM_W'(r_moved)) < SUM_W'(HW_FIFO_DEPTH))
               && (r_tx_cnt != '0);
        busy = (r_inflight != '0) || (r_tx_cnt != '0);
    end

    always_comb begin
        n_char_bits = r_char_bits;
        n_infl_lim  = r_infl_lim;
        n_item      = r_item;
        n_acc       = r_acc;
        n_moved     = r_moved;
        n_tx_head   = r_tx_head;
        n_tx_cnt    = r_tx_cnt;
        n_rx_head   = r_rx_head;
        n_rx_cnt    = r_rx_cnt;
        n_inflight  = r_inflight;
        n_dropped   = r_dropped;
        n_res       = r_res;
        tx_we = 1'b0;
        tx_re = 1'b0;
        rx_we = 1'b0;
        rx_re = 1'b0;

        if (i_cfg.we) begin
            if (i_cfg.idx == CFG_CHAR_BITS) n_char_bits = i_cfg.data;
            if (i_cfg.idx == CFG_INFL_LIMIT) n_infl_lim = i_cfg.data;
        end

        if (i_cmd.latch) begin
            n_item  = i_item;
            n_moved = '0;
        end

        if (i_cmd.exec) begin
            n_acc = 1'b0;
            case (r_item.func)
                FUNC_PUSH: begin
                    if (r_tx_cnt < TX_CW'(TX_DEPTH)) begin
                        tx_we    = 1'b1;
                        n_tx_cnt = r_tx_cnt + TX_CW'(1);
                        n_acc    = 1'b1;
                    end
                end
                FUNC_RET: begin
                    if (r_rx_cnt < RX_CW'(RX_DEPTH)) begin
                        rx_we    = 1'b1;
                        n_rx_cnt = r_rx_cnt + RX_CW'(1);
                    end else begin
                        n_dropped = r_dropped + DROP_W'(1);
                    end
                    if (r_inflight != '0) n_inflight = r_inflight - INFL_W'(1);
                end
                FUNC_POP: begin
                    if (r_rx_cnt != '0) begin
                        rx_re     = 1'b1;
                        n_rx_head = (r_rx_head == RX_AW'(RX_DEPTH - 1)) ? '0
                                  : r_rx_head + RX_AW'(1);
                        n_rx_cnt  = r_rx_cnt - RX_CW'(1);
                        n_acc     = 1'b1;
                    end
                end
                default: begin
                    n_rx_head = '0;
                    n_rx_cnt  = '0;
                end
            endcase
        end

        if (i_cmd.step) begin
            tx_re      = 1'b1;
            n_tx_head  = (r_tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_head + TX_AW'(1);
            n_tx_cnt   = r_tx_cnt - TX_CW'(1);
            n_inflight = r_inflight + INFL_W'(1);
            n_moved    = r_moved + MOVED_W'(1);
        end

        if (i_cmd.ld_stat || i_cmd.ld_pop || i_cmd.ld_pump) begin
            n_res.accepted       = r_acc;
            n_res.busy_res       = busy;
            n_res.in_flight      = r_inflight;
            n_res.overflow_count = r_dropped;
            n_res.rx_level       = LVL_W'(r_rx_cnt);
            n_res.tx_level       = LVL_W'(r_tx_cnt);
            n_res.last           = 1'b1;
            n_res.word           = '0;
            n_res.kind           = KIND_STAT;
            if (i_cmd.ld_pop) begin
                n_res.kind = KIND_POP;
                n_res.word = r_acc ? rx_rdata : '0;
            end
            if (i_cmd.ld_pump) begin
                n_res.kind = KIND_SENT;
                n_res.word = WORD_W'((tx_rdata & mask) << lsh);
                n_res.last = !pump_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_bits <= CHAR_BITS_RST;
            r_infl_lim  <= INFL_LIMIT_RST;
            r_tx_head   <= '0;
            r_tx_cnt    <= '0;
            r_rx_head   <= '0;
            r_rx_cnt    <= '0;
            r_inflight  <= '0;
            r_dropped   <= '0;
            r_moved     <= '0;
        end else begin
            r_char_bits <= n_char_bits;
            r_infl_lim  <= n_infl_lim;
            r_tx_head   <= n_tx_head;
            r_tx_cnt    <= n_tx_cnt;
            r_rx_head   <= n_rx_head;
            r_rx_cnt    <= n_rx_cnt;
            r_inflight  <= n_inflight;
            r_dropped   <= n_dropped;
            r_moved     <= n_moved;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    cgsfb_ram #(.WIDTH(WORD_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_tail),
        .i_wdata (masked_in),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    cgsfb_ram #(.WIDTH(WORD_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_tail),
        .i_wdata (masked_in),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    assign o_stat.func     = r_item.func;
    assign o_stat.eob      = r_item.eob;
    assign o_stat.pump_ok  = pump_ok;
    assign o_stat.out_last = r_res.last;
    assign o_res           = r_res;

endmodule

`default_nettype wire

// ----- design/cgsfb_checker.sv -----
`default_nettype none

module cgsfb_checker import cgsfb_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [KIND_W-1:0] i_out_kind,
    input wire logic [WORD_W-1:0] i_out_word,
    input wire logic              i_out_last,
    input wire logic [INFL_W-1:0] i_out_in_flight
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
            && $stable(i_out_kind) && $stable(i_out_last))
        else $error("stalled result changed");

    // One request at a time: never take a request while a result is pending.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request taken while result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    // Pop and status requests give a single result; status carries no word.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_POP || i_out_kind == KIND_STAT) |-> i_out_last)
        else $error("pop or status result not last");

    a_stat_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_STAT |->
            i_out_word == '0 && i_out_in_flight <= INFL_W'(INFL_CAP))
        else $error("bad status result");

endmodule

bind credit_gated_spi_fifo_bridge cgsfb_checker u_cgsfb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_word      (o_out.word),
    .i_out_last      (o_out.last),
    .i_out_in_flight (o_out.in_flight)
);

`default_nettype wire
